// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the particle stream ring manager.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PSRM_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("assertion failed");
`define PSRM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define PSRM_ASSERT(lbl, prop)
`define PSRM_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: src/psrm_pkg.sv
// ----------------------------------------------------------------------------
// Particle stream ring manager package
// Types, constants and helper functions shared by the block's modules.
// ----------------------------------------------------------------------------
package psrm_pkg;

    localparam int RING_SLOTS_DEF = 16;
    localparam int SEED_W          = 128;
    localparam logic [31:0] FRAME_TIME = 32'd1092;
    localparam logic [23:0] LIFE_RST   = 24'd65536;
    localparam logic [31:0] COUNT_MAX  = 32'h7FFF_FFFF;
    localparam logic [31:0] COUNT_MIN  = 32'h8000_0000;

    typedef struct packed {
        logic [SEED_W-1:0] seed;
        logic [31:0]       count;
        logic [31:0]       rate;
        logic [31:0]       spacing;
        logic [31:0]       age;
    } t_entry;

    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_LATCH,
        CMD_DIV_START,
        CMD_EMIT_OFF,
        CMD_EMIT_RATE,
        CMD_OPEN,
        CMD_WRITE,
        CMD_WRITE_NEXT,
        CMD_PTR_OLDEST,
        CMD_PTR_NEWEST,
        CMD_PTR_NEXT,
        CMD_AGE,
        CMD_LOAD,
        CMD_MUL_BIRTH,
        CMD_SET_BIRTH,
        CMD_MUL_DEATH,
        CMD_SET_DEAD,
        CMD_SUB_DEAD,
        CMD_MUL_BACK,
        CMD_PULL_AGE,
        CMD_JUMP_START,
        CMD_SEED_LOAD,
        CMD_RETIRE,
        CMD_EMIT
    } t_dp_cmd;

    typedef struct packed {
        logic open_req;
        logic full;
        logic live_zero;
        logic emitting;
        logic idx_last;
        logic div_busy;
        logic age_gt_life;
        logic keep;
        logic jump_busy;
        logic out_busy;
    } t_dp_status;

    function automatic logic [SEED_W-1:0] seed_step(input logic [SEED_W-1:0] s);
        logic [31:0] t;
        logic [31:0] s0;
        logic [31:0] s1;
        logic [31:0] s2;
        logic [31:0] s3;
        t  = s[127:96];
        s0 = {t[30:0], t[4] ^ t[22]};
        s1 = s[63:32] ^ s0;
        s2 = s[95:64] ^ s1;
        s3 = t ^ s2;
        return {s3, s2, s1, s0};
    endfunction

    function automatic logic [31:0] plus_one_sat(input logic [31:0] hi);
        return (hi >= COUNT_MAX) ? COUNT_MAX : hi + 32'd1;
    endfunction

endpackage

// File: src/psrm_seed_jump.sv
// ----------------------------------------------------------------------------
// Seed jump unit
// Advances a 128-bit seed by n steps using matrix squaring over GF(2).
// ----------------------------------------------------------------------------
module psrm_seed_jump (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [psrm_pkg::SEED_W-1:0] i_seed,
    input  logic [30:0]                i_count,
    output logic                       o_busy,
    output logic [psrm_pkg::SEED_W-1:0] o_seed
);
    import psrm_pkg::*;

    localparam logic [2:0] J_IDLE    = 3'd0;
    localparam logic [2:0] J_BUILD   = 3'd1;
    localparam logic [2:0] J_BIT     = 3'd2;
    localparam logic [2:0] J_APPLY   = 3'd3;
    localparam logic [2:0] J_SHIFT   = 3'd4;
    localparam logic [2:0] J_SQ_RD   = 3'd5;
    localparam logic [2:0] J_SQ_WAIT = 3'd6;
    localparam logic [2:0] J_SQ_MV   = 3'd7;

    logic [2:0]        r_st;
    logic [30:0]       r_n;
    logic [SEED_W-1:0] r_seed;
    logic [SEED_W-1:0] r_col;
    logic [SEED_W-1:0] r_acc;
    logic [7:0]        r_k;
    logic [6:0]        r_j;
    logic              r_bank;
    logic              r_pv;
    logic [6:0]        r_pk;
    logic [SEED_W-1:0] r_rdata;
    logic [SEED_W-1:0] mat_mem [256];

    logic [7:0]        raddr;
    logic              wen;
    logic [7:0]        waddr;
    logic [SEED_W-1:0] wdata;
    logic [SEED_W-1:0] vec;
    logic              mv_done;

    assign mv_done = r_k[7] && !r_pv;
    assign vec     = (r_st == J_APPLY) ? r_seed : r_col;
    assign raddr   = (r_st == J_SQ_RD) ? {r_bank, r_j} : {r_bank, r_k[6:0]};
    assign o_busy  = (r_st != J_IDLE);
    assign o_seed  = r_seed;

    always_comb begin
        wen   = 1'b0;
        waddr = {r_bank, r_j};
        wdata = r_acc;
        if (r_st == J_BUILD) begin
            wen   = 1'b1;
            wdata = seed_step(SEED_W'(1) << r_j);
        end else if (r_st == J_SQ_MV && mv_done) begin
            wen   = 1'b1;
            waddr = {~r_bank, r_j};
        end
    end

    always_ff @(posedge i_clk) begin
        if (wen) begin
            mat_mem[waddr] <= wdata;
        end
        r_rdata <= mat_mem[raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= J_IDLE;
            r_pv <= 1'b0;
        end else begin
            r_pv <= (r_st == J_APPLY || r_st == J_SQ_MV) && !r_k[7];
            if (r_st == J_APPLY || r_st == J_SQ_MV) begin
                if (!r_k[7]) begin
                    r_pk <= r_k[6:0];
                    r_k  <= r_k + 8'd1;
                end
                if (r_pv && vec[r_pk]) begin
                    r_acc <= r_acc ^ r_rdata;
                end
            end
            unique case (r_st)
                J_IDLE: begin
                    if (i_start) begin
                        r_seed <= i_seed;
                        r_n    <= i_count;
                        r_j    <= '0;
                        r_bank <= 1'b0;
                        r_st   <= J_BUILD;
                    end
                end
                J_BUILD: begin
                    r_j <= r_j + 7'd1;
                    if (r_j == 7'd127) begin
                        r_st <= J_BIT;
                    end
                end
                J_BIT: begin
                    if (r_n[0]) begin
                        r_acc <= '0;
                        r_k   <= '0;
                        r_st  <= J_APPLY;
                    end else begin
                        r_st <= J_SHIFT;
                    end
                end
                J_APPLY: begin
                    if (mv_done) begin
                        r_seed <= r_acc;
                        r_st   <= J_SHIFT;
                    end
                end
                J_SHIFT: begin
                    r_n <= r_n >> 1;
                    if (r_n[30:1] == '0) begin
                        r_st <= J_IDLE;
                    end else begin
                        r_j  <= '0;
                        r_st <= J_SQ_RD;
                    end
                end
                J_SQ_RD: begin
                    r_st <= J_SQ_WAIT;
                end
                J_SQ_WAIT: begin
                    r_col <= r_rdata;
                    r_acc <= '0;
                    r_k   <= '0;
                    r_st  <= J_SQ_MV;
                end
                J_SQ_MV: begin
                    if (mv_done) begin
                        r_j <= r_j + 7'd1;
                        if (r_j == 7'd127) begin
                            r_bank <= ~r_bank;
                            r_st   <= J_BIT;
                        end else begin
                            r_st <= J_SQ_RD;
                        end
                    end
                end
                default: r_st <= J_IDLE;
            endcase
        end
    end

endmodule

// File: src/psrm_dpath.sv
// ----------------------------------------------------------------------------
// Particle stream ring datapath
// Stream memory, ring pointers, divider, multiplier, seed jump and output.
// ----------------------------------------------------------------------------
module psrm_dpath #(
    parameter int RING_SLOTS = psrm_pkg::RING_SLOTS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  psrm_pkg::t_dp_cmd     i_cmd,
    output psrm_pkg::t_dp_status  o_st,
    input  logic                  i_cfg_we,
    input  logic [23:0]           i_cfg_wdata,
    input  logic [159:0]          i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [255:0]          o_out_data,
    output logic                  o_out_user,
    output logic                  o_out_last
);
    import psrm_pkg::*;

    localparam int PTR_W  = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;
    localparam int LIVE_W = $clog2(RING_SLOTS + 1);

    t_entry             stream_mem [RING_SLOTS];
    t_entry             r_rd;
    t_entry             r_w;
    logic [23:0]        r_lifetime;
    logic [31:0]        r_in_rate;
    logic [SEED_W-1:0]  r_in_seed;
    logic [31:0]        r_newest_rate;
    logic               r_emit;
    logic [LIVE_W-1:0]  r_live;
    logic [LIVE_W-1:0]  r_idx;
    logic [PTR_W-1:0]   r_oldest;
    logic [PTR_W-1:0]   r_newest;
    logic [PTR_W-1:0]   r_ptr;
    logic [63:0]        r_prod;
    logic [30:0]        r_dead;
    logic [31:0]        r_total;
    logic [5:0]         r_div_cnt;
    logic [31:0]        r_rem;
    logic [32:0]        r_quo;
    logic               r_out_valid;
    logic [255:0]       r_out_data;
    logic               r_out_user;
    logic               r_out_last;

    logic [31:0]        mul_a;
    logic [31:0]        mul_b;
    logic [32:0]        trial;
    logic [31:0]        spacing;
    logic [31:0]        aged;
    logic [31:0]        dead_full;
    logic signed [33:0] cnt_diff;
    logic [31:0]        total_new;
    logic [31:0]        pulled;
    logic               jump_busy;
    logic [SEED_W-1:0]  jump_seed;

    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(RING_SLOTS - 1)) ? '0 : p + 1'b1;
    endfunction

    psrm_seed_jump u_jump (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd == CMD_JUMP_START),
        .i_seed  (r_w.seed),
        .i_count (r_dead),
        .o_busy  (jump_busy),
        .o_seed  (jump_seed)
    );

    assign trial     = {r_rem, (r_div_cnt == 6'd33)};
    assign spacing   = r_quo[32] ? 32'hFFFF_FFFF : r_quo[31:0];
    assign aged      = (r_rd.age > (32'hFFFF_FFFF - FRAME_TIME)) ? 32'hFFFF_FFFF
                                                                 : r_rd.age + FRAME_TIME;
    assign dead_full = plus_one_sat(r_prod[63:32]);
    assign cnt_diff  = {{2{r_w.count[31]}}, r_w.count} - {3'b000, r_dead};
    assign total_new = r_total + r_rd.count;
    assign pulled    = (r_prod >= {32'd0, r_w.age}) ? 32'd0 : r_w.age - r_prod[31:0];

    always_comb begin
        mul_a = r_w.age;
        mul_b = r_w.rate;
        unique case (i_cmd)
            CMD_MUL_DEATH: begin
                mul_a = r_w.age - {8'd0, r_lifetime};
                mul_b = r_w.rate;
            end
            CMD_MUL_BACK: begin
                mul_a = {1'b0, r_dead};
                mul_b = r_w.spacing;
            end
            default: begin
                mul_a = r_w.age;
                mul_b = r_w.rate;
            end
        endcase
    end

    always_comb begin
        o_st.open_req    = (r_in_rate != '0) && (!r_emit || r_in_rate != r_newest_rate);
        o_st.full        = (r_live == LIVE_W'(RING_SLOTS));
        o_st.live_zero   = (r_live == '0);
        o_st.emitting    = r_emit;
        o_st.idx_last    = ({1'b0, r_idx} + 1'b1) == {1'b0, r_live};
        o_st.div_busy    = (r_div_cnt != '0);
        o_st.age_gt_life = (r_w.age > {8'd0, r_lifetime});
        o_st.keep        = ($signed(r_w.count) > 32'sd0) || (r_live == LIVE_W'(1) && r_emit);
        o_st.jump_busy   = jump_busy;
        o_st.out_busy    = r_out_valid;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd == CMD_WRITE || i_cmd == CMD_WRITE_NEXT) begin
            stream_mem[r_ptr] <= r_w;
        end
        r_rd <= stream_mem[r_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lifetime  <= LIFE_RST;
            r_emit      <= 1'b0;
            r_live      <= '0;
            r_oldest    <= '0;
            r_newest    <= PTR_W'(RING_SLOTS - 1);
            r_div_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_lifetime <= i_cfg_wdata;
            end
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (r_div_cnt != '0) begin
                r_div_cnt <= r_div_cnt - 6'd1;
                if (trial >= {1'b0, r_in_rate}) begin
                    r_rem <= 32'(trial - {1'b0, r_in_rate});
                    r_quo <= {r_quo[31:0], 1'b1};
                end else begin
                    r_rem <= trial[31:0];
                    r_quo <= {r_quo[31:0], 1'b0};
                end
            end
            unique case (i_cmd)
                CMD_LATCH: begin
                    r_in_rate <= i_in_data[31:0];
                    r_in_seed <= i_in_data[159:32];
                end
                CMD_DIV_START: begin
                    r_div_cnt <= 6'd33;
                    r_rem     <= '0;
                    r_quo     <= '0;
                end
                CMD_EMIT_OFF:  r_emit <= 1'b0;
                CMD_EMIT_RATE: r_emit <= (r_in_rate != '0);
                CMD_OPEN: begin
                    r_ptr         <= next_ptr(r_newest);
                    r_newest      <= next_ptr(r_newest);
                    r_live        <= r_live + 1'b1;
                    r_emit        <= 1'b1;
                    r_newest_rate <= r_in_rate;
                    r_w.seed      <= r_in_seed;
                    r_w.count     <= '0;
                    r_w.rate      <= r_in_rate;
                    r_w.spacing   <= spacing;
                    r_w.age       <= '0;
                end
                CMD_WRITE_NEXT, CMD_PTR_NEXT: begin
                    r_ptr <= next_ptr(r_ptr);
                    r_idx <= r_idx + 1'b1;
                end
                CMD_PTR_OLDEST: begin
                    r_ptr   <= r_oldest;
                    r_idx   <= '0;
                    r_total <= '0;
                end
                CMD_PTR_NEWEST: r_ptr <= r_newest;
                CMD_AGE: r_w <= {r_rd.seed, r_rd.count, r_rd.rate, r_rd.spacing, aged};
                CMD_LOAD: r_w <= r_rd;
                CMD_MUL_BIRTH, CMD_MUL_DEATH, CMD_MUL_BACK: begin
                    r_prod <= 64'(mul_a) * 64'(mul_b);
                end
                CMD_SET_BIRTH: r_w.count <= dead_full;
                CMD_SET_DEAD:  r_dead <= dead_full[30:0];
                CMD_SUB_DEAD: begin
                    if (cnt_diff < -34'sd2147483648) begin
                        r_w.count <= COUNT_MIN;
                    end else begin
                        r_w.count <= cnt_diff[31:0];
                    end
                end
                CMD_PULL_AGE:  r_w.age <= pulled;
                CMD_SEED_LOAD: r_w.seed <= jump_seed;
                CMD_RETIRE: begin
                    r_live   <= r_live - 1'b1;
                    r_oldest <= next_ptr(r_oldest);
                end
                CMD_EMIT: begin
                    r_total     <= total_new;
                    r_out_valid <= 1'b1;
                    r_out_data  <= {total_new, r_rd.seed, r_rd.count, r_rd.spacing, r_rd.age};
                    r_out_user  <= (r_ptr == r_newest);
                    r_out_last  <= o_st.idx_last;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_out_user  = r_out_user;
    assign o_out_last  = r_out_last;

endmodule

// File: src/psrm_ctrl.sv
// ----------------------------------------------------------------------------
// Particle stream ring controller
// Sequences one frame tick through the datapath by command and status.
// ----------------------------------------------------------------------------
module psrm_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  psrm_pkg::t_dp_status i_st,
    output psrm_pkg::t_dp_cmd    o_cmd
);
    import psrm_pkg::*;

    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_DECIDE   = 5'd1;
    localparam logic [4:0] S_DIV      = 5'd2;
    localparam logic [4:0] S_WR_NEW   = 5'd3;
    localparam logic [4:0] S_CHK_LIVE = 5'd4;
    localparam logic [4:0] S_AG_RD    = 5'd5;
    localparam logic [4:0] S_AG_LD    = 5'd6;
    localparam logic [4:0] S_AG_WR    = 5'd7;
    localparam logic [4:0] S_NW_SEL   = 5'd8;
    localparam logic [4:0] S_NW_RD    = 5'd9;
    localparam logic [4:0] S_NW_LD    = 5'd10;
    localparam logic [4:0] S_NW_MUL   = 5'd11;
    localparam logic [4:0] S_NW_SET   = 5'd12;
    localparam logic [4:0] S_NW_WR    = 5'd13;
    localparam logic [4:0] S_OD_PTR   = 5'd14;
    localparam logic [4:0] S_OD_RD    = 5'd15;
    localparam logic [4:0] S_OD_LD    = 5'd16;
    localparam logic [4:0] S_OD_CHK   = 5'd17;
    localparam logic [4:0] S_OD_DEAD  = 5'd18;
    localparam logic [4:0] S_OD_SUB   = 5'd19;
    localparam logic [4:0] S_OD_DEC   = 5'd20;
    localparam logic [4:0] S_OD_PULL  = 5'd21;
    localparam logic [4:0] S_OD_JUMP  = 5'd22;
    localparam logic [4:0] S_OD_JWAIT = 5'd23;
    localparam logic [4:0] S_OD_WR    = 5'd24;
    localparam logic [4:0] S_OD_RET   = 5'd25;
    localparam logic [4:0] S_LS_PTR   = 5'd26;
    localparam logic [4:0] S_LS_RD    = 5'd27;
    localparam logic [4:0] S_LS_WAIT  = 5'd28;
    localparam logic [4:0] S_LS_NEXT  = 5'd29;

    logic [4:0] r_state;
    logic [4:0] n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = CMD_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd   = CMD_LATCH;
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_st.open_req && !i_st.full) begin
                    o_cmd   = CMD_DIV_START;
                    n_state = S_DIV;
                end else if (i_st.open_req) begin
                    o_cmd   = CMD_EMIT_OFF;
                    n_state = S_CHK_LIVE;
                end else begin
                    o_cmd   = CMD_EMIT_RATE;
                    n_state = S_CHK_LIVE;
                end
            end
            S_DIV: begin
                if (!i_st.div_busy) begin
                    o_cmd   = CMD_OPEN;
                    n_state = S_WR_NEW;
                end
            end
            S_WR_NEW: begin
                o_cmd   = CMD_WRITE;
                n_state = S_CHK_LIVE;
            end
            S_CHK_LIVE: begin
                if (i_st.live_zero) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd   = CMD_PTR_OLDEST;
                    n_state = S_AG_RD;
                end
            end
            S_AG_RD: n_state = S_AG_LD;
            S_AG_LD: begin
                o_cmd   = CMD_AGE;
                n_state = S_AG_WR;
            end
            S_AG_WR: begin
                o_cmd   = CMD_WRITE_NEXT;
                n_state = i_st.idx_last ? S_NW_SEL : S_AG_RD;
            end
            S_NW_SEL: begin
                if (i_st.emitting) begin
                    o_cmd   = CMD_PTR_NEWEST;
                    n_state = S_NW_RD;
                end else begin
                    n_state = S_OD_PTR;
                end
            end
            S_NW_RD: n_state = S_NW_LD;
            S_NW_LD: begin
                o_cmd   = CMD_LOAD;
                n_state = S_NW_MUL;
            end
            S_NW_MUL: begin
                o_cmd   = CMD_MUL_BIRTH;
                n_state = S_NW_SET;
            end
            S_NW_SET: begin
                o_cmd   = CMD_SET_BIRTH;
                n_state = S_NW_WR;
            end
            S_NW_WR: begin
                o_cmd   = CMD_WRITE;
                n_state = S_OD_PTR;
            end
            S_OD_PTR: begin
                o_cmd   = CMD_PTR_OLDEST;
                n_state = S_OD_RD;
            end
            S_OD_RD: n_state = S_OD_LD;
            S_OD_LD: begin
                o_cmd   = CMD_LOAD;
                n_state = S_OD_CHK;
            end
            S_OD_CHK: begin
                if (i_st.age_gt_life) begin
                    o_cmd   = CMD_MUL_DEATH;
                    n_state = S_OD_DEAD;
                end else begin
                    n_state = S_LS_PTR;
                end
            end
            S_OD_DEAD: begin
                o_cmd   = CMD_SET_DEAD;
                n_state = S_OD_SUB;
            end
            S_OD_SUB: begin
                o_cmd   = CMD_SUB_DEAD;
                n_state = S_OD_DEC;
            end
            S_OD_DEC: begin
                if (i_st.keep) begin
                    o_cmd   = CMD_MUL_BACK;
                    n_state = S_OD_PULL;
                end else begin
                    o_cmd   = CMD_RETIRE;
                    n_state = S_OD_RET;
                end
            end
            S_OD_PULL: begin
                o_cmd   = CMD_PULL_AGE;
                n_state = S_OD_JUMP;
            end
            S_OD_JUMP: begin
                o_cmd   = CMD_JUMP_START;
                n_state = S_OD_JWAIT;
            end
            S_OD_JWAIT: begin
                if (!i_st.jump_busy) begin
                    o_cmd   = CMD_SEED_LOAD;
                    n_state = S_OD_WR;
                end
            end
            S_OD_WR: begin
                o_cmd   = CMD_WRITE;
                n_state = S_LS_PTR;
            end
            S_OD_RET: n_state = i_st.live_zero ? S_IDLE : S_LS_PTR;
            S_LS_PTR: begin
                o_cmd   = CMD_PTR_OLDEST;
                n_state = S_LS_RD;
            end
            S_LS_RD: n_state = S_LS_WAIT;
            S_LS_WAIT: begin
                if (!i_st.out_busy) begin
                    o_cmd   = CMD_EMIT;
                    n_state = S_LS_NEXT;
                end
            end
            S_LS_NEXT: begin
                if (i_st.idx_last) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd   = CMD_PTR_NEXT;
                    n_state = S_LS_RD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: src/particle_stream_ring_manager_core.sv
// ----------------------------------------------------------------------------
// Particle stream ring manager core
// Keeps a ring of particle streams and lists them once per frame tick.
// ----------------------------------------------------------------------------
// Each request on the s_axis channel is one frame tick: the emit rate and four
// random words. The block may open a stream, ages every live stream, updates
// the newest stream's count while it emits, trims or retires the oldest
// stream once it outlives the lifetime and then sends one request per live
// stream on the m_axis channel, oldest first, with tlast on the final one.
// A tick with no live stream sends nothing. A tick takes longer with each
// live stream and with the time that the receiver holds off results.
// Opening a stream adds the reciprocal divider and the write of the new
// entry. Trimming the oldest stream runs the seed jump unit: it builds its
// matrix, applies it for each set bit of the death count and squares it for
// each further bit of that count, bound by the one read port of its matrix
// memory. One tick is taken at a time.
// Reset empties the ring and loads the lifetime register with one second.
// A stalled receiver holds the current result in the output register and
// the block waits; the next tick is accepted once the last result is staged.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module particle_stream_ring_manager_core #(
    parameter int RING_SLOTS = psrm_pkg::RING_SLOTS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [23:0]  i_cfg_wdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // emit_rate, random_word_0, random_word_1, random_word_2, random_word_3
    input  logic [159:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // oldest_age, spacing, particle_count, seed_out_0, seed_out_1,
    // seed_out_2, seed_out_3, running_total
    output logic [255:0] m_axis_tdata,
    // is_newest
    output logic         m_axis_tuser,
    output logic         m_axis_tlast
);
    import psrm_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_st;

    psrm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_st       (w_st),
        .o_cmd      (w_cmd)
    );

    psrm_dpath #(
        .RING_SLOTS (RING_SLOTS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_st        (w_st),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_data   (s_axis_tdata),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata),
        .o_out_user  (m_axis_tuser),
        .o_out_last  (m_axis_tlast)
    );

    `PSRM_ASSERT(a_idle_units, s_axis_tready |-> (!w_st.div_busy && !w_st.jump_busy))
    `PSRM_ASSERT(a_open_room, (w_cmd == CMD_OPEN) |-> !w_st.full)
    `PSRM_ASSERT(a_emit_free, (w_cmd == CMD_EMIT) |-> !w_st.out_busy)
    `PSRM_ASSERT_NEXT(a_emit_shows, (w_cmd == CMD_EMIT), m_axis_tvalid)

endmodule

// File: test/tb_particle_stream_ring_manager_core.sv
// ----------------------------------------------------------------------------
// Particle stream ring manager core testbench
// Sends frame ticks with random idling on both channels, predicts every
// listed stream from its own model of the ring and compares each result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_particle_stream_ring_manager_core;
    import psrm_pkg::*;

    localparam int RING = RING_SLOTS_DEF;

    typedef struct {
        logic [31:0]  age;
        logic [31:0]  spacing;
        logic [31:0]  count;
        logic         newest;
        logic [127:0] seed;
        logic [31:0]  total;
        logic         last;
    } t_stream_row;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_cfg_we;
    logic [23:0]  i_cfg_wdata;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [159:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [255:0] m_axis_tdata;
    logic         m_axis_tuser;
    logic         m_axis_tlast;

    particle_stream_ring_manager_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    // Model state of the ring.
    logic [31:0]  ring_age[RING];
    logic [31:0]  ring_spacing[RING];
    logic [31:0]  ring_rate[RING];
    logic [31:0]  ring_count[RING];
    logic [127:0] ring_seed[RING];
    int           head_old;
    int           head_new;
    int           live_cnt;
    bit           emitting;
    logic [23:0]  life_reg;

    t_stream_row  listing_q[$];
    int           errors;
    bit           idle_on;
    int           rx_stall = 0;
    logic [31:0]  last_rate;

    initial begin
        i_clk = 1'b0;
        forever begin
            #6 i_clk = 1'b1;
            #6 i_clk = 1'b0;
        end
    end

    initial begin
        #(64'd5_000_000_000);
        $display("FAIL particle_stream_ring_manager_core");
        $finish;
    end

    function automatic int ring_next(int i);
        return (i + 1 >= RING) ? 0 : i + 1;
    endfunction

    function automatic logic [127:0] lfsr_once(logic [127:0] s);
        logic [31:0] hi;
        logic [31:0] w0;
        logic [31:0] w1;
        logic [31:0] w2;
        hi = s[127:96];
        w0 = {hi[30:0], hi[4] ^ hi[22]};
        w1 = s[63:32] ^ w0;
        w2 = s[95:64] ^ w1;
        return {hi ^ w2, w2, w1, w0};
    endfunction

    // Jumps the seed by n steps with a squared step matrix held as columns.
    function automatic logic [127:0] lfsr_jump(logic [127:0] s, logic [31:0] n);
        logic [127:0] col[128];
        logic [127:0] sq[128];
        logic [127:0] acc;
        logic [127:0] v;
        for (int j = 0; j < 128; j++) col[j] = lfsr_once(128'd1 << j);
        while (n != 0) begin
            if (n[0]) begin
                acc = '0;
                for (int j = 0; j < 128; j++) if (s[j]) acc ^= col[j];
                s = acc;
            end
            n = n >> 1;
            if (n != 0) begin
                for (int k = 0; k < 128; k++) begin
                    v = col[k];
                    acc = '0;
                    for (int j = 0; j < 128; j++) if (v[j]) acc ^= col[j];
                    sq[k] = acc;
                end
                col = sq;
            end
        end
        return s;
    endfunction

    function automatic logic [31:0] mul_hi_plus_one(logic [31:0] a, logic [31:0] b);
        logic [63:0] v;
        v = ((64'(a) * 64'(b)) >> 32) + 64'd1;
        return (v > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : v[31:0];
    endfunction

    task automatic predict_tick(logic [159:0] item);
        logic [31:0] rate;
        logic [63:0] sp;
        logic [31:0] dead;
        logic [31:0] total;
        logic [63:0] back;
        longint      c;
        int          p;
        t_stream_row row;
        rate = item[31:0];
        if (rate != 0 && (!emitting || rate != ring_rate[head_new])) begin
            if (live_cnt < RING) begin
                sp = (64'd1 << 32) / rate;
                live_cnt++;
                head_new = ring_next(head_new);
                ring_rate[head_new] = rate;
                ring_spacing[head_new] = (sp > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sp[31:0];
                ring_age[head_new] = '0;
                ring_count[head_new] = '0;
                ring_seed[head_new] = item[159:32];
                emitting = 1'b1;
            end else begin
                emitting = 1'b0;
            end
        end else begin
            emitting = (rate != 0);
        end
        if (live_cnt == 0) return;
        p = head_old;
        for (int i = 0; i < live_cnt; i++) begin
            ring_age[p] = (ring_age[p] > 32'hFFFF_FFFF - FRAME_TIME) ? 32'hFFFF_FFFF
                          : ring_age[p] + FRAME_TIME;
            p = ring_next(p);
        end
        if (emitting)
            ring_count[head_new] = mul_hi_plus_one(ring_age[head_new], ring_rate[head_new]);
        p = head_old;
        if (ring_age[p] > 32'(life_reg)) begin
            dead = mul_hi_plus_one(ring_age[p] - 32'(life_reg), ring_rate[p]);
            c = longint'($signed(ring_count[p])) - longint'(dead);
            if (c < -64'sd2147483648) c = -64'sd2147483648;
            ring_count[p] = c[31:0];
            if (c > 0 || (live_cnt == 1 && emitting)) begin
                back = 64'(dead) * 64'(ring_spacing[p]);
                ring_age[p] = (back >= 64'(ring_age[p])) ? 32'd0 : ring_age[p] - back[31:0];
                ring_seed[p] = lfsr_jump(ring_seed[p], dead);
            end else begin
                live_cnt--;
                head_old = ring_next(head_old);
                if (live_cnt == 0) return;
            end
        end
        total = '0;
        p = head_old;
        for (int i = 0; i < live_cnt; i++) begin
            total += ring_count[p];
            row.age     = ring_age[p];
            row.spacing = ring_spacing[p];
            row.count   = ring_count[p];
            row.newest  = (p == head_new);
            row.seed    = ring_seed[p];
            row.total   = total;
            row.last    = (i + 1 == live_cnt);
            listing_q.push_back(row);
            p = ring_next(p);
        end
    endtask

    task automatic report_mismatch(string what, logic [127:0] got, logic [127:0] want);
        errors++;
        $display("mismatch %s: got %h want %h", what, got, want);
    endtask

    always @(posedge i_clk) begin
        t_stream_row want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (listing_q.size() == 0) begin
                report_mismatch("unexpected result", m_axis_tdata[127:0], '0);
            end else begin
                want = listing_q.pop_front();
                if (m_axis_tdata[31:0] !== want.age)
                    report_mismatch("oldest_age", 128'(m_axis_tdata[31:0]), 128'(want.age));
                if (m_axis_tdata[63:32] !== want.spacing)
                    report_mismatch("spacing", 128'(m_axis_tdata[63:32]),
                                    128'(want.spacing));
                if (m_axis_tdata[95:64] !== want.count)
                    report_mismatch("particle_count", 128'(m_axis_tdata[95:64]),
                                    128'(want.count));
                if (m_axis_tdata[223:96] !== want.seed)
                    report_mismatch("seed", m_axis_tdata[223:96], want.seed);
                if (m_axis_tdata[255:224] !== want.total)
                    report_mismatch("running_total", 128'(m_axis_tdata[255:224]),
                                    128'(want.total));
                if (m_axis_tuser !== want.newest)
                    report_mismatch("is_newest", 128'(m_axis_tuser), 128'(want.newest));
                if (m_axis_tlast !== want.last)
                    report_mismatch("last_stream", 128'(m_axis_tlast), 128'(want.last));
            end
        end
    end

    always @(negedge i_clk) begin
        if (!idle_on) begin
            m_axis_tready <= 1'b1;
        end else if (rx_stall > 0) begin
            rx_stall--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            if ($urandom_range(0, 9) == 0) rx_stall = $urandom_range(1, 18);
        end
    end

    task automatic send_tick(logic [31:0] rate, logic [127:0] words);
        int gap;
        gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 18) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {words, rate};
        do @(posedge i_clk); while (!s_axis_tready);
        predict_tick({words, rate});
        last_rate = rate;
    endtask

    task automatic drain_ring;
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (listing_q.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_lifetime(logic [23:0] value);
        drain_ring();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        life_reg = value;
    endtask

    function automatic logic [127:0] rand_words();
        return {$urandom, $urandom, $urandom, $urandom};
    endfunction

    task automatic test_rate_extremes;
        send_tick(32'd0, rand_words());
        send_tick(32'hFFFF_FFFF, {128{1'b1}});
        send_tick(32'hFFFF_FFFF, rand_words());
        send_tick(32'd1, '0);
        send_tick(32'd0, rand_words());
        send_tick(32'h0001_0000, rand_words());
    endtask

    task automatic test_ring_full;
        write_lifetime(24'hFF_FFFF);
        for (int i = 0; i < 13; i++) send_tick(32'h0000_4000 + i, rand_words());
        send_tick(32'h0000_8000, rand_words());
        send_tick(32'h0000_8000, rand_words());
        send_tick(32'd0, rand_words());
    endtask

    task automatic test_lifetime_zero;
        write_lifetime(24'd0);
        for (int i = 0; i < 6; i++) send_tick(32'd0, rand_words());
        send_tick(32'h0000_2000, rand_words());
        send_tick(32'h0000_2000, rand_words());
    endtask

    task automatic test_random_ticks(int n, logic [23:0] life);
        logic [31:0] rate;
        int pick;
        write_lifetime(life);
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 40)      rate = last_rate;
            else if (pick < 55) rate = 32'd0;
            else if (pick < 96) rate = $urandom_range(1, 32'h0004_0000);
            else                rate = $urandom;
            send_tick(rate, rand_words());
        end
    endtask

    initial begin
        errors        = 0;
        idle_on       = 1'b1;
        last_rate     = '0;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        head_old      = 0;
        head_new      = RING - 1;
        live_cnt      = 0;
        emitting      = 1'b0;
        life_reg      = LIFE_RST;
        for (int i = 0; i < RING; i++) begin
            ring_age[i] = '0; ring_spacing[i] = '0; ring_rate[i] = '0;
            ring_count[i] = '0; ring_seed[i] = '0;
        end
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_rate_extremes();
        test_ring_full();
        test_lifetime_zero();
        test_random_ticks(38, 24'($urandom_range(0, 5000)));
        test_random_ticks(38, LIFE_RST);
        test_random_ticks(38, 24'($urandom));
        drain_ring();
        idle_on = 1'b0;
        test_random_ticks(38, 24'($urandom_range(0, 3000)));

        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (listing_q.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (errors == 0 && listing_q.size() == 0) begin
            $display("PASS particle_stream_ring_manager_core");
        end else begin
            $display("FAIL particle_stream_ring_manager_core");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+src
src/psrm_pkg.sv
src/psrm_seed_jump.sv
src/psrm_dpath.sv
src/psrm_ctrl.sv
src/particle_stream_ring_manager_core.sv
test/tb_particle_stream_ring_manager_core.sv
